FILE: hw/rtl/sfd_pkg.sv
// Shared types and constants for the serial frame deframer.
// Used by every module under hw/rtl; depends on nothing.
package sfd_pkg;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam logic [7:0] TYPE_PERC  = 8'h10;
  localparam logic [7:0] TYPE_POS   = 8'h11;
  localparam logic [7:0] END_FIRST  = 8'h0D;
  localparam logic [7:0] END_SECOND = 8'h0A;

  localparam logic [5:0] LEN_PERC  = 6'd44;
  localparam logic [5:0] LEN_POS   = 6'd24;
  localparam logic [5:0] FLAG_OFS  = 6'd4;
  localparam logic [5:0] WORD_OFS  = 6'd5;

  localparam logic [2:0] FLAG_MASK_PERC = 3'h7;
  localparam logic [2:0] FLAG_MASK_POS  = 3'h1;

  localparam int         WORD_DEPTH = 9;
  localparam int         WORD_AW    = $clog2(WORD_DEPTH);
  localparam logic [WORD_AW-1:0] LAST_WORD_PERC = WORD_AW'(8);
  localparam logic [WORD_AW-1:0] LAST_WORD_POS  = WORD_AW'(3);

  localparam logic [1:0] KIND_POS     = 2'd0;
  localparam logic [1:0] KIND_PERC    = 2'd1;
  localparam logic [1:0] KIND_OFFLINE = 2'd2;

  localparam int          TICK_BITS     = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } sfd_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  valid_flags;
    logic [3:0]  word_index;
    logic [31:0] word_value;
    logic        last;
  } sfd_out_t;

  // Work handed from the parser to the emitter.
  typedef struct packed {
    logic       offline;
    logic       perception;
    logic [2:0] flags;
  } sfd_cmd_t;

  // Payload word write into the emitter's word store.
  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
    logic [31:0]        data;
  } sfd_wr_t;

endpackage

FILE: hw/rtl/serial_frame_deframer_with_timeout.sv
// Top level of the serial frame deframer with link timeout.
// Depends on sfd_pkg, sfd_front, sfd_queue and sfd_back.
//
// Each input transaction is either a received byte or a one-millisecond
// tick. Bytes are parsed for the header AA 55 and a type byte (10h for a
// 44-byte perception frame, 11h for a 24-byte position frame); the body is
// checked for an 8-bit additive checksum over offsets 2 up to the byte
// before the checksum and for the 0D 0A trailer. A good frame brings the
// link online, clears the tick count and yields 9 or 4 result transactions,
// one per little-endian payload word, with the masked flag byte attached
// and last set on the final word. Ticks saturate at the counter's all-ones
// value; when an online link's count exceeds timeout_ms it drops offline
// and one result of kind 2 is sent. Payload words are assembled in the
// parser and written to a nine-word store; the emitter pops the command,
// then reads and sends each frame word in turn, waiting out any output
// stall, and sends an offline event at once. While a good frame's words are
// still being sent, in_ready is low (the store holds only one frame), so the
// byte after a frame's last byte waits until the last word has been sent.
// A two-entry command queue keeps parser and emitter apart.
// cfg_ready is always high; write timeout_ms only while the block is idle.
module serial_frame_deframer_with_timeout
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sfd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output sfd_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic     q_full;
  logic     q_nonempty;
  logic     q_push;
  logic     q_pop;
  sfd_cmd_t q_cmd;
  sfd_cmd_t q_head;
  sfd_wr_t  wr;
  logic     frame_done;

  // Configuration writes never stall.
  assign cfg_ready = 1'b1;

  // Parse bytes, count ticks, push frame and offline transactions.
  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .wr         (wr),
    .frame_done (frame_done)
  );

  // Hold pending work in order between the two sides.
  sfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .nonempty (q_nonempty),
    .pop      (q_pop),
    .head     (q_head)
  );

  // Drain commands into result transactions.
  sfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .frame_done (frame_done)
  );

endmodule

FILE: hw/rtl/sfd_front.sv
// Front part: byte parser, checksum, tick counter and link state.
// Depends on sfd_pkg; feeds sfd_queue and the word store in sfd_back.
module sfd_front
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sfd_in_t     in_data,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  logic        q_full,
  output logic        q_push,
  output sfd_cmd_t    q_cmd,
  output sfd_wr_t     wr,
  input  logic        frame_done
);

  localparam logic [1:0] PH_HUNT_A = 2'd0;
  localparam logic [1:0] PH_HUNT_B = 2'd1;
  localparam logic [1:0] PH_TYPE   = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  logic [1:0]           phase_r, phase_nxt;
  logic [5:0]           count_r, count_nxt;
  logic                 perc_r, perc_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic [7:0]           ck_r, ck_nxt;
  logic [7:0]           t0_r, t0_nxt;
  logic [2:0]           flags_r, flags_nxt;
  logic [31:0]          word_r, word_nxt;
  logic                 online_r, online_nxt;
  logic [TICK_BITS-1:0] ticks_r, ticks_nxt;
  logic [15:0]          timeout_r;
  logic                 pend_r, pend_nxt;

  logic                 in_fire;
  logic [7:0]           b;
  logic [5:0]           len;
  logic [5:0]           off5;
  logic [TICK_BITS-1:0] ticks_inc;

  assign in_ready = !pend_r && !q_full;
  assign in_fire  = in_valid && in_ready;
  assign b        = in_data.byte_value;
  assign len      = perc_r ? LEN_PERC : LEN_POS;
  assign off5     = count_r - WORD_OFS;
  assign ticks_inc = (ticks_r != {TICK_BITS{1'b1}}) ? ticks_r + 1'b1 : ticks_r;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    perc_nxt   = perc_r;
    sum_nxt    = sum_r;
    ck_nxt     = ck_r;
    t0_nxt     = t0_r;
    flags_nxt  = flags_r;
    word_nxt   = word_r;
    online_nxt = online_r;
    ticks_nxt  = ticks_r;
    pend_nxt   = pend_r && !frame_done;
    q_push     = 1'b0;
    q_cmd      = '0;
    wr         = '0;
    if (in_fire && in_data.operation == OP_TICK) begin
      ticks_nxt = ticks_inc;
      if (online_r && (ticks_inc > timeout_r)) begin
        online_nxt    = 1'b0;
        q_push        = 1'b1;
        q_cmd.offline = 1'b1;
      end
    end else if (in_fire) begin
      unique case (phase_r)
        PH_HUNT_A: begin
          if (b == HDR_FIRST) phase_nxt = PH_HUNT_B;
        end
        PH_HUNT_B: begin
          if (b == HDR_SECOND) phase_nxt = PH_TYPE;
          else if (b != HDR_FIRST) phase_nxt = PH_HUNT_A;
        end
        PH_TYPE: begin
          sum_nxt   = b;
          count_nxt = 6'd3;
          if (b == TYPE_PERC) begin
            perc_nxt  = 1'b1;
            phase_nxt = PH_BODY;
          end else if (b == TYPE_POS) begin
            perc_nxt  = 1'b0;
            phase_nxt = PH_BODY;
          end else begin
            phase_nxt = PH_HUNT_A;
          end
        end
        default: begin
          count_nxt = count_r + 1'b1;
          if (count_r == FLAG_OFS) flags_nxt = b[2:0];
          // Checksum covers the type byte up to the byte before the checksum.
          if (count_r + 6'd4 <= len) sum_nxt = sum_r + b;
          if (count_r >= WORD_OFS && count_r + 6'd4 <= len) begin
            word_nxt = {b, word_r[31:8]};
            if (off5[1:0] == 2'd3) begin
              wr.en   = 1'b1;
              wr.addr = off5[WORD_AW+1:2];
              wr.data = {b, word_r[31:8]};
            end
          end
          if (count_r == len - 6'd3) ck_nxt = b;
          if (count_r == len - 6'd2) t0_nxt = b;
          if (count_r == len - 6'd1) begin
            phase_nxt = PH_HUNT_A;
            if (sum_r == ck_r && t0_r == END_FIRST && b == END_SECOND) begin
              online_nxt       = 1'b1;
              ticks_nxt        = '0;
              pend_nxt         = 1'b1;
              q_push           = 1'b1;
              q_cmd.perception = perc_r;
              q_cmd.flags      = flags_r & (perc_r ? FLAG_MASK_PERC : FLAG_MASK_POS);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT_A;
      count_r   <= '0;
      perc_r    <= 1'b0;
      sum_r     <= '0;
      online_r  <= 1'b0;
      ticks_r   <= '0;
      timeout_r <= TIMEOUT_RESET;
      pend_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      perc_r   <= perc_nxt;
      sum_r    <= sum_nxt;
      online_r <= online_nxt;
      ticks_r  <= ticks_nxt;
      pend_r   <= pend_nxt;
      if (cfg_valid) timeout_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    ck_r    <= ck_nxt;
    t0_r    <= t0_nxt;
    flags_r <= flags_nxt;
    word_r  <= word_nxt;
  end

`ifndef ASSERT_OFF
  a_offline: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_cmd.offline) |=> !online_r && pend_r == $past(pend_r && !frame_done))
    else $error("offline event left link online");
`endif

endmodule

FILE: hw/rtl/sfd_queue.sv
// Short command queue between the parser and the emitter.
// Depends on sfd_pkg for the command type and depth.
module sfd_queue
  import sfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sfd_cmd_t push_cmd,
  output logic     full,
  output logic     nonempty,
  input  logic     pop,
  output sfd_cmd_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sfd_cmd_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("pop from empty queue");
`endif

endmodule

FILE: hw/rtl/sfd_back.sv
// Back part: word store and result sequencer.
// Depends on sfd_pkg; takes commands from sfd_queue and words from sfd_front.
module sfd_back
  import sfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sfd_wr_t  wr,
  input  logic     q_nonempty,
  input  sfd_cmd_t q_head,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output sfd_out_t out_data,
  output logic     frame_done
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [31:0]        mem [WORD_DEPTH];
  logic [31:0]        rdata_r;
  logic [1:0]         state_r, state_nxt;
  logic [WORD_AW-1:0] idx_r, idx_nxt;
  sfd_cmd_t           cur_r, cur_nxt;
  logic               is_last;
  logic               out_fire;

  assign out_valid = (state_r == ST_SEND);
  assign out_fire  = out_valid && out_ready;
  assign is_last   = cur_r.offline ||
                     (idx_r == (cur_r.perception ? LAST_WORD_PERC : LAST_WORD_POS));
  assign q_pop      = (state_r == ST_IDLE) && q_nonempty;
  assign frame_done = out_fire && is_last && !cur_r.offline;

  always_comb begin
    out_data             = '0;
    out_data.last        = is_last;
    out_data.result_kind = cur_r.offline ? KIND_OFFLINE :
                           (cur_r.perception ? KIND_PERC : KIND_POS);
    if (!cur_r.offline) begin
      out_data.valid_flags = cur_r.flags;
      out_data.word_index  = 4'(idx_r);
      out_data.word_value  = rdata_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_nonempty) begin
          cur_nxt   = q_head;
          idx_nxt   = '0;
          // An offline event carries no word; send it at once.
          state_nxt = q_head.offline ? ST_SEND : ST_READ;
        end
      end
      ST_READ: state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_fire) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rdata_r <= mem[idx_r];
  end

`ifndef ASSERT_OFF
  a_offline_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cur_r.offline) |-> out_data.last)
    else $error("offline event not marked last");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r <= LAST_WORD_PERC))
    else $error("word index out of range");
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && !cur_r.offline) |-> !wr.en)
    else $error("word store written while a frame is being sent");
`endif

endmodule

FILE: verif/deframer_checker.sv
`timescale 1ns / 1ps
// In-order result checker for the serial frame deframer with link timeout.
// Watches the byte/tick, result and timeout-register channels and predicts every result.
// Depends on sfd_pkg for the transaction structs and the frame constants.
module deframer_checker
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  sfd_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  sfd_out_t    out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          awaited_count,
  output int          checked_count
);

  typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, TAKE_TYPE, TAKE_BODY} parse_phase_e;

  parse_phase_e phase;
  logic [5:0]   rx_count;
  logic         perc_frame;
  logic [7:0]   body_sum;
  logic [7:0]   frame_buf [64];
  logic         link_up;
  logic [15:0]  idle_ticks;
  logic [15:0]  timeout_limit;

  sfd_out_t awaited_results[$];
  int       mismatches = 0;
  int       checked = 0;

  // Verify checksum and trailer of a finished frame, then queue its payload words.
  task automatic emit_frame_words();
    int         len;
    int         words;
    int         base;
    logic [2:0] flags;
    sfd_out_t   r;
    len = perc_frame ? int'(LEN_PERC) : int'(LEN_POS);
    if (frame_buf[len-3] != body_sum) return;
    if (frame_buf[len-2] != END_FIRST || frame_buf[len-1] != END_SECOND) return;
    link_up    = 1'b1;
    idle_ticks = '0;
    words = perc_frame ? int'(LAST_WORD_PERC) + 1 : int'(LAST_WORD_POS) + 1;
    flags = frame_buf[FLAG_OFS][2:0] & (perc_frame ? FLAG_MASK_PERC : FLAG_MASK_POS);
    for (int k = 0; k < words; k++) begin
      base = int'(WORD_OFS) + 4 * k;
      r.result_kind = perc_frame ? KIND_PERC : KIND_POS;
      r.valid_flags = flags;
      r.word_index  = 4'(k);
      r.word_value  = {frame_buf[base+3], frame_buf[base+2],
                       frame_buf[base+1], frame_buf[base]};
      r.last        = (k == words - 1);
      awaited_results.push_back(r);
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    int len;
    case (phase)
      HUNT_FIRST: begin
        if (b == HDR_FIRST) begin
          frame_buf[0] = b;
          rx_count     = 6'd1;
          phase        = HUNT_SECOND;
        end
      end
      HUNT_SECOND: begin
        if (b == HDR_SECOND) begin
          frame_buf[1] = b;
          rx_count     = 6'd2;
          phase        = TAKE_TYPE;
        end else if (b == HDR_FIRST) begin
          frame_buf[0] = b;
          rx_count     = 6'd1;
        end else begin
          phase = HUNT_FIRST;
        end
      end
      TAKE_TYPE: begin
        frame_buf[2] = b;
        rx_count     = 6'd3;
        body_sum     = b;
        if (b == TYPE_PERC) begin
          perc_frame = 1'b1;
          phase      = TAKE_BODY;
        end else if (b == TYPE_POS) begin
          perc_frame = 1'b0;
          phase      = TAKE_BODY;
        end else begin
          phase = HUNT_FIRST;
        end
      end
      default: begin
        len = perc_frame ? int'(LEN_PERC) : int'(LEN_POS);
        frame_buf[rx_count] = b;
        // the checksum covers everything from the type byte up to the byte before it
        if (int'(rx_count) + 4 <= len) body_sum = body_sum + b;
        rx_count = rx_count + 6'd1;
        if (int'(rx_count) >= len) begin
          phase = HUNT_FIRST;
          emit_frame_words();
        end
      end
    endcase
  endtask

  task automatic advance_tick();
    sfd_out_t r;
    if (idle_ticks != '1) idle_ticks = idle_ticks + 16'd1;
    if (link_up && idle_ticks > timeout_limit) begin
      link_up = 1'b0;
      r = '0;
      r.result_kind = KIND_OFFLINE;
      r.last        = 1'b1;
      awaited_results.push_back(r);
    end
  endtask

  task automatic check_result(input sfd_out_t got);
    sfd_out_t want;
    checked++;
    if (awaited_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, nothing awaited; got kind %0d flags %0h index %0d",
               $time, got.result_kind, got.valid_flags, got.word_index,
               " word %08h last %0b", got.word_value, got.last);
      return;
    end
    want = awaited_results.pop_front();
    if (got.result_kind !== want.result_kind || got.valid_flags !== want.valid_flags ||
        got.word_index !== want.word_index || got.word_value !== want.word_value ||
        got.last !== want.last) begin
      mismatches++;
      $display("%0t: result mismatch, expected kind %0d flags %0h index %0d word %08h last %0b",
               $time, want.result_kind, want.valid_flags, want.word_index,
               want.word_value, want.last);
      $display("%0t:                  got      kind %0d flags %0h index %0d word %08h last %0b",
               $time, got.result_kind, got.valid_flags, got.word_index,
               got.word_value, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase         = HUNT_FIRST;
      rx_count      = '0;
      perc_frame    = 1'b0;
      body_sum      = '0;
      link_up       = 1'b0;
      idle_ticks    = '0;
      timeout_limit = TIMEOUT_RESET;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (cfg_valid && cfg_ready) timeout_limit = cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.operation == OP_TICK) advance_tick();
        else parse_rx_byte(in_data.byte_value);
      end
    end
    mismatch_count <= mismatches;
    awaited_count  <= awaited_results.size();
    checked_count  <= checked;
  end

endmodule

FILE: verif/serial_frame_deframer_with_timeout_test.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte/tick stimulus, timeout writes, verdict.
// Depends on sfd_pkg, deframer_checker and serial_frame_deframer_with_timeout.
module serial_frame_deframer_with_timeout_test;
  import sfd_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Hold-off after the last result, covering frames that are dropped silently.
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 8;

  // Idle profiles of the random phases: none, sender only, receiver only, both.
  localparam int SEND_IDLE[4]     = '{0, 49, 0, 30};
  localparam int RECV_STALL[4]    = '{0, 0, 49, 30};
  localparam logic [15:0] PHASE_TIMEOUT[4] = '{16'd3, 16'd25, 16'd1, 16'd12};

  typedef enum logic [1:0] {FLAW_NONE, FLAW_CHECKSUM, FLAW_TRAILER} frame_flaw_e;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} payload_fill_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  sfd_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sfd_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int mismatch_count;
  int awaited_count;
  int checked_count;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;
  int          frames_sent = 0;
  int          quiet_cycles = 0;
  logic [15:0] timeout_now = TIMEOUT_RESET;

  serial_frame_deframer_with_timeout dut (.*);

  deframer_checker result_check (.*);

  always #2 clk = ~clk;

  // Receiver side: stall at random with the current phase's rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any accepted transaction on any channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still awaited",
               $time, STALL_LIMIT, awaited_count);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte or tick and hold it until the block takes it. Idle cycles
  // go in front of the item; valid is left high after acceptance so that a
  // back-to-back item never lowers and raises it in the same step.
  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, byte_value: b};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid, wait for every awaited result, then hold off a while longer.
  task automatic wait_until_drained(input int hold_cycles);
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    repeat (hold_cycles) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    wait_until_drained(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    timeout_now = value;
  endtask

  // Build a frame with a correct checksum and trailer, optionally damage it,
  // and send its first keep_bytes bytes with ticks mixed in at tick_pct.
  task automatic send_frame(input logic perception, input logic [7:0] flags,
                            input payload_fill_e fill, input frame_flaw_e flaw,
                            input int keep_bytes, input int tick_pct);
    logic [7:0] frame_bytes [44];
    logic [7:0] csum;
    int         len;
    len = perception ? int'(LEN_PERC) : int'(LEN_POS);
    frame_bytes[0] = HDR_FIRST;
    frame_bytes[1] = HDR_SECOND;
    frame_bytes[2] = perception ? TYPE_PERC : TYPE_POS;
    for (int i = 3; i < len - 3; i++) begin
      case (fill)
        FILL_ZERO: frame_bytes[i] = 8'h00;
        FILL_ONES: frame_bytes[i] = 8'hFF;
        default:   frame_bytes[i] = 8'($urandom);
      endcase
    end
    frame_bytes[FLAG_OFS] = flags;
    csum = '0;
    for (int i = 2; i < len - 3; i++) csum = csum + frame_bytes[i];
    frame_bytes[len-3] = csum;
    frame_bytes[len-2] = END_FIRST;
    frame_bytes[len-1] = END_SECOND;
    // a nonzero flip guarantees the damaged byte really differs
    if (flaw == FLAW_CHECKSUM)
      frame_bytes[len-3] ^= 8'($urandom_range(1, 255));
    else if (flaw == FLAW_TRAILER)
      frame_bytes[len-2+$urandom_range(1)] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < len && i < keep_bytes; i++) begin
      if ($urandom_range(99) < tick_pct) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, frame_bytes[i]);
    end
    if (keep_bytes >= len) frames_sent++;
  endtask

  // One random sequence: mostly well-formed frames with random content, the
  // rest damaged or cut frames, tick bursts, line noise and broken headers.
  task automatic random_sequence();
    int            pick;
    logic          perc;
    payload_fill_e fill;
    pick = $urandom_range(99);
    perc = 1'($urandom_range(1));
    fill = FILL_RANDOM;
    if ($urandom_range(9) == 0) fill = $urandom_range(1) ? FILL_ZERO : FILL_ONES;
    if (pick < 55) begin
      send_frame(perc, 8'($urandom), fill, FLAW_NONE, 44, 5);
      // now and then let the whole backlog drain before going on
      if ($urandom_range(5) == 0) wait_until_drained(0);
    end else if (pick < 65) begin
      send_frame(perc, 8'($urandom), fill, FLAW_CHECKSUM, 44, 5);
    end else if (pick < 72) begin
      send_frame(perc, 8'($urandom), fill, FLAW_TRAILER, 44, 5);
    end else if (pick < 80) begin
      // long enough, often, to run past the timeout
      repeat ($urandom_range(1, int'(timeout_now) + 3)) send_item(OP_TICK, 8'($urandom));
    end else if (pick < 87) begin
      repeat ($urandom_range(1, 6))
        send_item(OP_BYTE, $urandom_range(3) == 0 ? HDR_FIRST : 8'($urandom));
    end else if (pick < 93) begin
      send_item(OP_BYTE, HDR_FIRST);
      if ($urandom_range(1)) send_item(OP_BYTE, HDR_FIRST);
      if ($urandom_range(1)) begin
        send_item(OP_BYTE, 8'($urandom));
      end else begin
        send_item(OP_BYTE, HDR_SECOND);
        send_item(OP_BYTE, 8'($urandom));
      end
    end else begin
      // cut short: the next bytes are swallowed into this frame's body
      send_frame(perc, 8'($urandom), fill, FLAW_NONE, $urandom_range(3, 43), 5);
    end
  endtask

  initial begin
    int phase_start;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling, timeout at its reset value.
    // Ticks while offline only count.
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'h00);
    // A doubled first header byte restarts the hunt; all-zero perception frame.
    send_item(OP_BYTE, HDR_FIRST);
    send_frame(1'b1, 8'h00, FILL_ZERO, FLAW_NONE, 44, 0);
    // Broken second header byte, then an unknown type byte.
    send_item(OP_BYTE, HDR_FIRST);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, HDR_FIRST);
    send_item(OP_BYTE, HDR_SECOND);
    send_item(OP_BYTE, 8'h12);
    // Position frame dropped for a bad checksum.
    send_frame(1'b0, 8'hFE, FILL_RANDOM, FLAW_CHECKSUM, 44, 0);
    // Short timeout: the third tick drops the link, the fourth only counts.
    write_timeout(16'd2);
    repeat (4) send_item(OP_TICK, 8'($urandom));

    // Zero timeout: the first tick after a frame drops the link.
    write_timeout(16'd0);
    send_frame(1'b0, 8'hFF, FILL_ONES, FLAW_NONE, 44, 0);
    send_item(OP_TICK, 8'h5A);
    send_item(OP_TICK, 8'hA5);

    // Random phases, one per idle profile, each with its own timeout.
    for (int p = 0; p < 4; p++) begin
      write_timeout(PHASE_TIMEOUT[p]);
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) random_sequence();
    end

    wait_until_drained(SETTLE_CYCLES);
    $display("summary: %0d byte/tick transactions, %0d whole frames, %0d results checked",
             items_sent, frames_sent, checked_count);
    $display("summary: timeouts 0, 1, 2, 3, 12, 25 and the reset value; four idle profiles");
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count, awaited_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: serial_frame_deframer_with_timeout.f
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_front.sv
hw/rtl/sfd_queue.sv
hw/rtl/sfd_back.sv
hw/rtl/serial_frame_deframer_with_timeout.sv
verif/deframer_checker.sv
verif/serial_frame_deframer_with_timeout_test.sv
